[hdl/tqe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqe_pkg
// Shared types, codes and defaults of the tree ancestor query engine.
// ----------------------------------------------------------------------------
package tqe_pkg;

	localparam int FIELD_W       = 10;
	localparam int OP_W          = 2;
	localparam int STAT_W        = 2;
	localparam int IN_TDATA_W    = 40;
	localparam int OUT_TDATA_W   = 16;
	localparam int DEF_MAX_NODES = 1024;
	localparam int DEF_LEVELS    = 11;

	localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
	localparam logic [OP_W-1:0] OP_LCA  = 2'd1;
	localparam logic [OP_W-1:0] OP_KTH  = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STAT_W-1:0] STAT_BAD  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NONE = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]    opcode;
		logic [FIELD_W-1:0] parent_id;
		logic [FIELD_W-1:0] node_a;
		logic [FIELD_W-1:0] node_b;
		logic [FIELD_W-1:0] step_count;
	} cmd_t;

	typedef struct packed {
		logic [FIELD_W-1:0] answer_node;
		logic [STAT_W-1:0]  status;
	} res_t;

endpackage

[hdl/tree_ancestor_query_engine_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tree_ancestor_query_engine_core
// Binary-lifting ancestor table with lca and k-th ancestor queries.
//
//   channel  dir  tdata                                          tuser
//   s_*      in   parent_id, node_a, node_b, step_count          opcode
//   m_*      out  answer_node                                    status
//
// one transaction at a time; a load, a k-th query and an lca query each
// walk the ancestor memory, one level per step
// a finished result sits in the output register while the next transaction
// is taken; reset clears only the state, the node count and the output valid
// flag, the memories need no clearing
// ----------------------------------------------------------------------------
module tree_ancestor_query_engine_core #(
	parameter int MAX_NODES = tqe_pkg::DEF_MAX_NODES,
	parameter int LEVELS    = tqe_pkg::DEF_LEVELS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// parent_id, node_a, node_b, step_count
	input  logic [tqe_pkg::IN_TDATA_W-1:0]      s_tdata,
	// opcode
	input  logic [tqe_pkg::OP_W-1:0]            s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// answer_node, zero padding
	output logic [tqe_pkg::OUT_TDATA_W-1:0]     m_tdata,
	// status
	output logic [tqe_pkg::STAT_W-1:0]          m_tuser
);

	import tqe_pkg::*;

	cmd_t cmd;
	res_t res;
	logic res_valid, res_ready;
	logic m_tvalid_q;
	logic [FIELD_W-1:0] answer_q;
	logic [STAT_W-1:0]  status_q;

	assign cmd.opcode     = s_tuser;
	assign cmd.parent_id  = s_tdata[FIELD_W-1:0];
	assign cmd.node_a     = s_tdata[2*FIELD_W-1:FIELD_W];
	assign cmd.node_b     = s_tdata[3*FIELD_W-1:2*FIELD_W];
	assign cmd.step_count = s_tdata[4*FIELD_W-1:3*FIELD_W];

	tqe_engine #(.MAX_NODES(MAX_NODES), .LEVELS(LEVELS)) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (s_tvalid),
		.cmd_ready (s_tready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			answer_q <= res.answer_node;
			status_q <= res.status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_TDATA_W'(answer_q);
	assign m_tuser  = status_q;

endmodule

[hdl/tqe_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqe_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module tqe_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

[hdl/tqe_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqe_engine
// Sequencer over the ancestor and depth memories: loads, lca and k-th climbs.
// ----------------------------------------------------------------------------
module tqe_engine #(
	parameter int MAX_NODES = tqe_pkg::DEF_MAX_NODES,
	parameter int LEVELS    = tqe_pkg::DEF_LEVELS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  tqe_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_ready,
	output tqe_pkg::res_t res
);

	import tqe_pkg::*;

	localparam int NW = $clog2(MAX_NODES);
	localparam int CW = $clog2(MAX_NODES + 1);
	localparam int LW = $clog2(LEVELS);
	localparam int AD = MAX_NODES * LEVELS;
	localparam int AW = $clog2(AD);
	localparam int XW = (CW > FIELD_W) ? CW : FIELD_W;
	localparam logic [LW-1:0] LAST_LVL = LW'(LEVELS - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(MAX_NODES);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_DEC     = 4'd1;
	localparam logic [3:0] S_LD_BASE = 4'd2;
	localparam logic [3:0] S_LD_RD   = 4'd3;
	localparam logic [3:0] S_LD_WR   = 4'd4;
	localparam logic [3:0] S_K_DEP   = 4'd5;
	localparam logic [3:0] S_L_DEP   = 4'd6;
	localparam logic [3:0] S_CL      = 4'd7;
	localparam logic [3:0] S_CL_WT   = 4'd8;
	localparam logic [3:0] S_LF_RD   = 4'd9;
	localparam logic [3:0] S_LF_CMP  = 4'd10;
	localparam logic [3:0] S_FIN_RD  = 4'd11;
	localparam logic [3:0] S_FIN     = 4'd12;
	localparam logic [3:0] S_DONE    = 4'd13;

	logic [3:0]        state_q, state_nxt;
	logic [CW-1:0]     count_q;
	cmd_t              cmd_q;
	logic [NW-1:0]     prev_q, cur_q, oth_q;
	logic [LW-1:0]     lvl_q;
	logic [LEVELS-1:0] k_q;
	logic [FIELD_W-1:0] ans_q;
	logic [STAT_W-1:0] stat_q;

	logic          anc_we, dep_we;
	logic [AW-1:0] anc_wa, anc_ra, anc_rb;
	logic [NW-1:0] anc_wd, anc_rd_a, anc_rd_b;
	logic [NW-1:0] dep_wa, dep_ra, dep_rb;
	logic [NW-1:0] dep_wd, dep_rd_a, dep_rd_b;

	logic [NW-1:0] new_node;
	logic          load_bad, a_bad, b_bad, root_load;

	function automatic logic [AW-1:0] anc_addr(input logic [NW-1:0] node,
		input logic [LW-1:0] lvl);
		anc_addr = AW'(node) * AW'(LEVELS) + AW'(lvl);
	endfunction

	tqe_ram #(.WIDTH(NW), .DEPTH(AD)) u_anc_ram (
		.clk     (clk),
		.we      (anc_we),
		.waddr   (anc_wa),
		.wdata   (anc_wd),
		.raddr_a (anc_ra),
		.raddr_b (anc_rb),
		.rdata_a (anc_rd_a),
		.rdata_b (anc_rd_b)
	);

	tqe_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_dep_ram (
		.clk     (clk),
		.we      (dep_we),
		.waddr   (dep_wa),
		.wdata   (dep_wd),
		.raddr_a (dep_ra),
		.raddr_b (dep_rb),
		.rdata_a (dep_rd_a),
		.rdata_b (dep_rd_b)
	);

	assign new_node  = NW'(count_q);
	assign root_load = (count_q == '0);
	assign load_bad  = (count_q == FULL_CNT)
		|| (!root_load && (XW'(cmd_q.parent_id) >= XW'(count_q)));
	assign a_bad     = XW'(cmd_q.node_a) >= XW'(count_q);
	assign b_bad     = XW'(cmd_q.node_b) >= XW'(count_q);

	assign cmd_ready       = (state_q == S_IDLE);
	assign res_valid       = (state_q == S_DONE);
	assign res.answer_node = ans_q;
	assign res.status      = stat_q;

	// memory ports
	always_comb begin
		anc_we = 1'b0;
		anc_wa = anc_addr(new_node, lvl_q);
		anc_wd = anc_rd_a;
		anc_ra = anc_addr(cur_q, lvl_q);
		anc_rb = anc_addr(oth_q, lvl_q);
		dep_we = 1'b0;
		dep_wa = new_node;
		dep_wd = root_load ? '0 : NW'(dep_rd_a + 1'b1);
		dep_ra = (cmd_q.opcode == OP_LOAD) ? NW'(cmd_q.parent_id) : NW'(cmd_q.node_a);
		dep_rb = NW'(cmd_q.node_b);
		unique case (state_q)
			S_LD_BASE: begin
				dep_we = 1'b1;
				anc_we = 1'b1;
				anc_wa = anc_addr(new_node, '0);
				anc_wd = root_load ? '0 : NW'(cmd_q.parent_id);
			end
			S_LD_RD: begin
				anc_ra = anc_addr(prev_q, lvl_q - 1'b1);
			end
			S_LD_WR: begin
				anc_we = 1'b1;
			end
			S_FIN_RD: begin
				anc_ra = anc_addr(cur_q, '0);
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) state_nxt = S_DEC;
			end
			S_DEC: begin
				unique case (cmd_q.opcode)
					OP_LOAD: state_nxt = load_bad ? S_DONE : S_LD_BASE;
					OP_LCA:  state_nxt = (a_bad || b_bad) ? S_DONE : S_L_DEP;
					OP_KTH:  state_nxt = a_bad ? S_DONE : S_K_DEP;
					default: state_nxt = S_DONE;
				endcase
			end
			S_LD_BASE: state_nxt = S_LD_RD;
			S_LD_RD:   state_nxt = S_LD_WR;
			S_LD_WR:   state_nxt = (lvl_q == LAST_LVL) ? S_DONE : S_LD_RD;
			S_K_DEP: begin
				state_nxt = (XW'(dep_rd_a) < XW'(cmd_q.step_count)) ? S_DONE : S_CL;
			end
			S_L_DEP:   state_nxt = S_CL;
			S_CL: begin
				if (k_q == '0) begin
					if (cmd_q.opcode == OP_KTH || cur_q == oth_q) state_nxt = S_DONE;
					else state_nxt = S_LF_RD;
				end else if (k_q[0]) begin
					state_nxt = S_CL_WT;
				end
			end
			S_CL_WT:   state_nxt = S_CL;
			S_LF_RD:   state_nxt = S_LF_CMP;
			S_LF_CMP:  state_nxt = (lvl_q == '0) ? S_FIN_RD : S_LF_RD;
			S_FIN_RD:  state_nxt = S_FIN;
			S_FIN:     state_nxt = S_DONE;
			S_DONE: begin
				if (res_ready) state_nxt = S_IDLE;
			end
			default:   state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == S_LD_WR && lvl_q == LAST_LVL) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) cmd_q <= cmd;
			end
			S_DEC: begin
				ans_q  <= '0;
				stat_q <= STAT_BAD;
			end
			S_LD_BASE: begin
				prev_q <= root_load ? '0 : NW'(cmd_q.parent_id);
				lvl_q  <= LW'(1);
			end
			S_LD_WR: begin
				prev_q <= anc_rd_a;
				lvl_q  <= lvl_q + 1'b1;
				if (lvl_q == LAST_LVL) begin
					ans_q  <= FIELD_W'(new_node);
					stat_q <= STAT_OK;
				end
			end
			S_K_DEP: begin
				if (XW'(dep_rd_a) < XW'(cmd_q.step_count)) begin
					stat_q <= STAT_NONE;
				end else begin
					cur_q <= NW'(cmd_q.node_a);
					k_q   <= LEVELS'(cmd_q.step_count);
					lvl_q <= '0;
				end
			end
			S_L_DEP: begin
				lvl_q <= '0;
				if (dep_rd_a < dep_rd_b) begin
					cur_q <= NW'(cmd_q.node_b);
					oth_q <= NW'(cmd_q.node_a);
					k_q   <= LEVELS'(dep_rd_b - dep_rd_a);
				end else begin
					cur_q <= NW'(cmd_q.node_a);
					oth_q <= NW'(cmd_q.node_b);
					k_q   <= LEVELS'(dep_rd_a - dep_rd_b);
				end
			end
			S_CL: begin
				if (k_q == '0) begin
					ans_q  <= FIELD_W'(cur_q);
					stat_q <= STAT_OK;
					lvl_q  <= LAST_LVL;
				end else if (!k_q[0]) begin
					k_q   <= k_q >> 1;
					lvl_q <= lvl_q + 1'b1;
				end
			end
			S_CL_WT: begin
				cur_q <= anc_rd_a;
				k_q   <= k_q >> 1;
				lvl_q <= lvl_q + 1'b1;
			end
			S_LF_CMP: begin
				if (anc_rd_a != anc_rd_b) begin
					cur_q <= anc_rd_a;
					oth_q <= anc_rd_b;
				end
				lvl_q <= lvl_q - 1'b1;
			end
			S_FIN: begin
				ans_q  <= FIELD_W'(anc_rd_a);
				stat_q <= STAT_OK;
			end
			default: begin
			end
		endcase
	end

endmodule

[dv/tree_ancestor_query_engine_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tree_ancestor_query_engine_core_test
// Self-checking bench for the ancestor query engine. Grows a tree of up to
// MAX_NODES nodes and mixes lca and k-th ancestor queries into the loads. It
// also sends bad parents, bad query nodes, too many levels, loads to a full
// table and the unused opcode. A scoreboard keeps its own lifting table,
// predicts every answer and checks the output stream in order. Random
// back-pressure is applied on both sides.
// ----------------------------------------------------------------------------
module tree_ancestor_query_engine_core_test;
	import tqe_pkg::*;

	localparam int MAX_NODES   = DEF_MAX_NODES;
	localparam int LEVELS      = DEF_LEVELS;
	localparam int RAND_ITEMS  = 1930;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int CALM_START  = 30000;
	localparam int CALM_END    = 45000;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	class lift_scoreboard;
		logic [FIELD_W-1:0] up_tbl [0:MAX_NODES-1][0:LEVELS-1];
		logic [FIELD_W-1:0] depth_of [0:MAX_NODES-1];
		logic [FIELD_W:0]   node_count;
		res_t               answer_q [$];
		int                 errors;

		function new();
			node_count = '0;
			errors = 0;
		endfunction

		function logic [FIELD_W-1:0] climb_up(logic [FIELD_W-1:0] node,
				logic [FIELD_W-1:0] k);
			for (int i = 0; i < LEVELS && i < FIELD_W; i++) begin
				if (k[i])
					node = up_tbl[node][i];
			end
			return node;
		endfunction

		function logic [FIELD_W-1:0] lca_of(logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b);
			logic [FIELD_W-1:0] t;
			if (depth_of[a] < depth_of[b]) begin
				t = a;
				a = b;
				b = t;
			end
			a = climb_up(a, depth_of[a] - depth_of[b]);
			if (a == b)
				return a;
			for (int i = LEVELS - 1; i >= 0; i--) begin
				if (up_tbl[a][i] != up_tbl[b][i]) begin
					a = up_tbl[a][i];
					b = up_tbl[b][i];
				end
			end
			return up_tbl[a][0];
		endfunction

		function void note_cmd(cmd_t c);
			res_t r;
			logic [FIELD_W-1:0] n;
			r.answer_node = '0;
			r.status = STAT_BAD;
			case (c.opcode)
				OP_LOAD: begin
					if (node_count < MAX_NODES) begin
						n = node_count[FIELD_W-1:0];
						if (node_count == 0 || c.parent_id < node_count) begin
							if (node_count == 0) begin
								up_tbl[0][0] = '0;
								depth_of[0] = '0;
							end else begin
								up_tbl[n][0] = c.parent_id;
								depth_of[n] = depth_of[c.parent_id] + 1'b1;
							end
							for (int j = 1; j < LEVELS; j++)
								up_tbl[n][j] = up_tbl[up_tbl[n][j-1]][j-1];
							node_count = node_count + 1'b1;
							r.answer_node = n;
							r.status = STAT_OK;
						end
					end
				end
				OP_LCA: begin
					if (c.node_a < node_count && c.node_b < node_count) begin
						r.answer_node = lca_of(c.node_a, c.node_b);
						r.status = STAT_OK;
					end
				end
				OP_KTH: begin
					if (c.node_a < node_count) begin
						if (depth_of[c.node_a] < c.step_count) begin
							r.status = STAT_NONE;
						end else begin
							r.answer_node = climb_up(c.node_a, c.step_count);
							r.status = STAT_OK;
						end
					end
				end
				default: ;
			endcase
			answer_q.push_back(r);
		endfunction

		function void check_result(logic [OUT_TDATA_W-1:0] tdata, logic [STAT_W-1:0] status);
			res_t want;
			if (answer_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: tdata %h status %0d", tdata, status);
				return;
			end
			want = answer_q.pop_front();
			if (tdata != {{(OUT_TDATA_W-FIELD_W){1'b0}}, want.answer_node} ||
					status != want.status) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected answer %0d status %0d, got tdata %h status %0d",
						want.answer_node, want.status, tdata, status);
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic [OP_W-1:0]        s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [STAT_W-1:0]      m_tuser;

	lift_scoreboard sb;
	int cycles = 0;
	bit calm = 1'b0;

	tree_ancestor_query_engine_core #(
		.MAX_NODES(MAX_NODES),
		.LEVELS   (LEVELS)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// no idling on either side inside the calm window
	always @(posedge clk) begin
		cycles <= cycles + 1;
		calm <= (cycles >= CALM_START && cycles < CALM_END);
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (arst_n)
			m_tready <= calm || ($urandom_range(99) >= 7);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);
	end

	task automatic send_cmd(logic [OP_W-1:0] op, logic [FIELD_W-1:0] par,
			logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b, logic [FIELD_W-1:0] k);
		cmd_t c;
		c.opcode = op;
		c.parent_id = par;
		c.node_a = a;
		c.node_b = b;
		c.step_count = k;
		while (!calm && $urandom_range(99) < 7) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {k, b, a, par};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_cmd(c);
		@(negedge clk);
	endtask

	function automatic logic [FIELD_W-1:0] rnd10();
		return FIELD_W'($urandom_range(MAX_NODES - 1));
	endfunction

	// mostly a loaded node, now and then one past the loaded range
	function automatic logic [FIELD_W-1:0] pick_node();
		int cnt;
		cnt = sb.node_count;
		if (cnt < MAX_NODES && $urandom_range(99) < 5)
			return FIELD_W'($urandom_range(MAX_NODES - 1, cnt));
		if (cnt > 64 && $urandom_range(99) < 40)
			return FIELD_W'($urandom_range(cnt - 1, cnt - 64));
		return FIELD_W'($urandom_range(cnt - 1));
	endfunction

	task automatic random_load();
		int cnt;
		int r;
		logic [FIELD_W-1:0] par;
		cnt = sb.node_count;
		r = $urandom_range(99);
		if (cnt >= MAX_NODES)
			par = rnd10();
		else if (r < 3)
			par = FIELD_W'($urandom_range(MAX_NODES - 1, cnt));
		else if (r < 63)
			par = FIELD_W'(cnt - 1);
		else
			par = FIELD_W'($urandom_range(cnt - 1));
		send_cmd(OP_LOAD, par, rnd10(), rnd10(), rnd10());
	endtask

	task automatic random_query();
		int r;
		int d;
		logic [FIELD_W-1:0] a;
		logic [FIELD_W-1:0] b;
		logic [FIELD_W-1:0] k;
		r = $urandom_range(99);
		a = pick_node();
		d = (a < sb.node_count) ? sb.depth_of[a] : 0;
		if (r < 3) begin
			send_cmd(OP_UNUSED, rnd10(), rnd10(), rnd10(), rnd10());
		end else if (r < 52) begin
			if (a < sb.node_count && $urandom_range(99) < 25)
				b = sb.climb_up(a, FIELD_W'($urandom_range(d)));
			else
				b = pick_node();
			send_cmd(OP_LCA, rnd10(), a, b, rnd10());
		end else begin
			r = $urandom_range(99);
			if (r < 40)
				k = FIELD_W'($urandom_range(d));
			else if (r < 55)
				k = FIELD_W'(d);
			else if (r < 80 && d < MAX_NODES - 1)
				k = FIELD_W'($urandom_range(MAX_NODES - 1, d + 1));
			else
				k = rnd10();
			send_cmd(OP_KTH, rnd10(), a, rnd10(), k);
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_LOAD;
		m_tready = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty table, unused opcode, root load ignores its parent
		send_cmd(OP_LCA, '0, '0, '0, '0);
		send_cmd(OP_KTH, '0, '0, '0, '0);
		send_cmd(OP_UNUSED, '0, '0, '0, '0);
		send_cmd(OP_LOAD, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
		send_cmd(OP_LOAD, 10'd1, '0, '0, '0);
		send_cmd(OP_LOAD, 10'd1023, '0, '0, '0);
		send_cmd(OP_KTH, '0, '0, '0, '0);
		send_cmd(OP_KTH, '0, '0, '0, 10'd1);
		send_cmd(OP_LOAD, 10'd0, '0, '0, '0);
		send_cmd(OP_LOAD, 10'd1, '0, '0, '0);
		send_cmd(OP_LOAD, 10'd2, '0, '0, '0);
		send_cmd(OP_LOAD, 10'd1, '0, '0, '0);
		send_cmd(OP_LCA, '0, 10'd3, 10'd4, '0);
		send_cmd(OP_LCA, '0, 10'd4, 10'd3, '0);
		send_cmd(OP_LCA, '0, 10'd3, 10'd3, '0);
		send_cmd(OP_LCA, '0, 10'd0, 10'd3, '0);
		send_cmd(OP_LCA, '0, 10'd3, 10'd5, '0);
		send_cmd(OP_LCA, '0, 10'd1023, 10'd0, '0);
		send_cmd(OP_KTH, '0, 10'd3, '0, 10'd3);
		send_cmd(OP_KTH, '0, 10'd3, '0, 10'd4);
		send_cmd(OP_KTH, '0, 10'd3, '0, 10'd1023);
		send_cmd(OP_KTH, '0, 10'd1023, '0, '0);
		send_cmd(OP_UNUSED, 10'd1023, 10'd1023, 10'd1023, 10'd1023);

		// loads mixed with queries until the table fills, then mostly queries and a few full loads
		for (int i = 0; i < RAND_ITEMS; i++) begin
			if ((sb.node_count < MAX_NODES && $urandom_range(99) < 58) ||
					(sb.node_count >= MAX_NODES && $urandom_range(99) < 4))
				random_load();
			else
				random_query();
		end
		s_tvalid <= 1'b0;

		while (sb.answer_q.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
		if (sb.errors == 0 && sb.answer_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
